[design/tal_pkg.sv]
// shared types and constants of the temperature alarm latch
package tal_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int THR_REGS = 4;
  localparam int TEMP_W   = 16;
  localparam int MARGIN_W = 12;
  localparam int CNT_W    = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] REMINDER_MS = 32'd1800000;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 8'hFF;

  localparam logic signed [TEMP_W-1:0] THRESHOLD_RST = 16'sd80;
  localparam logic [CHANNELS-1:0]      ENABLE_RST    = 4'hF;
  localparam logic [MARGIN_W-1:0]      NEAR_RST      = 12'd16;
  localparam logic [MARGIN_W-1:0]      HYST_RST      = 12'd16;
  localparam logic [CNT_W-1:0]         CONFIRM_RST   = 8'd3;

  typedef enum logic [1:0] {
    STAT_NORMAL = 2'd0,
    STAT_NEAR   = 2'd1,
    STAT_ALARM  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_REMIND  = 2'd2,
    EV_RECOVER = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR0    = 3'd0,
    REG_THR1    = 3'd1,
    REG_THR2    = 3'd2,
    REG_THR3    = 3'd3,
    REG_ENABLE  = 3'd4,
    REG_NEAR    = 3'd5,
    REG_HYST    = 3'd6,
    REG_CONFIRM = 3'd7
  } cfg_reg_t;

  // one channel's entry in the state memory
  typedef struct packed {
    status_t           status;
    logic              latched;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] last;
  } ch_state_t;

endpackage

[design/tal_if.sv]
// stream and configuration interfaces of the temperature alarm latch
interface tal_in_if import tal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel;
  logic signed [TEMP_W-1:0] temperature;
  logic                     reading_valid;
  logic [TIME_W-1:0]        now_ms;

  modport source (output valid, channel, temperature, reading_valid, now_ms, input ready);
  modport sink   (input valid, channel, temperature, reading_valid, now_ms, output ready);
endinterface

interface tal_out_if import tal_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  logic [1:0]      status;
  logic            alarm_latched;
  logic [1:0]      event_res;
  logic            any_latched;

  modport source (output valid, out_channel, status, alarm_latched, event_res, any_latched,
                  input ready);
  modport sink   (input valid, out_channel, status, alarm_latched, event_res, any_latched,
                  output ready);
endinterface

interface tal_cfg_if import tal_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/temperature_alarm_latch.sv]
// top level: per-channel alarm state in a small memory, read-modify-write per reading
// a reading is registered with its state memory entry on accept, then its update is
//   registered in the result register (read, then update)
// throughput: one reading per cycle unless results stall; a result follows the same channel
//   back to back through forwarding of the value written in the update stage
// reset (rst, synchronous): registers back to defaults, every channel normal and unlatched
//   via per-entry valid bits; no clearing pass
module temperature_alarm_latch import tal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tal_in_if.sink    sample,
  tal_out_if.source result,
  tal_cfg_if.sink   cfg
);

  // configuration registers
  logic signed [TEMP_W-1:0] thr [THR_REGS];
  logic [CHANNELS-1:0]      enable_mask;
  logic [MARGIN_W-1:0]      near_margin;
  logic [MARGIN_W-1:0]      hysteresis;
  logic [CNT_W-1:0]         confirm_count;

  // state memory
  ch_state_t           mem [CHANNELS];
  logic [CHANNELS-1:0] entry_vld;
  logic [CHANNELS-1:0] lat_vec;

  // update stage
  logic                     s1_valid;
  logic [CH_W-1:0]          s1_ch;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     s1_rvalid;
  logic [TIME_W-1:0]        s1_now;
  ch_state_t                rd_data;
  logic                     rd_vld;
  logic                     fwd_hit;
  ch_state_t                fwd_data;

  logic       accept;
  logic       s1_adv;
  logic       ch_ok;
  ch_state_t  cur;
  ch_state_t  upd;
  event_t     ev;
  logic [CHANNELS-1:0] lat_next;

  logic signed [TEMP_W+1:0] t_x;
  logic signed [TEMP_W+1:0] thr_x;
  logic signed [TEMP_W+1:0] near_lvl;
  logic signed [TEMP_W+1:0] clear_lvl;
  logic                     over;
  logic [CNT_W-1:0]         cnt_inc;
  logic [TIME_W-1:0]        elapsed;

  // output register
  logic            o_valid;
  logic [CH_W-1:0] o_ch;
  status_t         o_status;
  logic            o_latched;
  event_t          o_event;
  logic            o_any;

  assign cfg.ready    = 1'b1;
  assign s1_adv       = s1_valid && (!o_valid || result.ready);
  assign sample.ready = !s1_valid || s1_adv;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THR_REGS; i++) thr[i] <= THRESHOLD_RST;
      enable_mask   <= ENABLE_RST;
      near_margin   <= NEAR_RST;
      hysteresis    <= HYST_RST;
      confirm_count <= CONFIRM_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_THR0:    thr[0] <= cfg.data;
        REG_THR1:    thr[1] <= cfg.data;
        REG_THR2:    thr[2] <= cfg.data;
        REG_THR3:    thr[3] <= cfg.data;
        REG_ENABLE:  enable_mask   <= cfg.data[CHANNELS-1:0];
        REG_NEAR:    near_margin   <= cfg.data[MARGIN_W-1:0];
        REG_HYST:    hysteresis    <= cfg.data[MARGIN_W-1:0];
        REG_CONFIRM: confirm_count <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read port: registered on accept, held while the update stage stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data   <= mem[sample.channel];
      s1_ch     <= sample.channel;
      s1_temp   <= sample.temperature;
      s1_rvalid <= sample.reading_valid;
      s1_now    <= sample.now_ms;
      fwd_data  <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rd_vld   <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        rd_vld   <= entry_vld[sample.channel];
        // same channel being written this edge: take the new value instead
        fwd_hit  <= s1_adv && ch_ok && (s1_ch == sample.channel);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (s1_adv && ch_ok) mem[s1_ch] <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      lat_vec   <= '0;
    end else if (s1_adv && ch_ok) begin
      entry_vld[s1_ch] <= 1'b1;
      lat_vec          <= lat_next;
    end
  end

  always_comb begin
    ch_ok = ({1'b0, s1_ch} < (CH_W+1)'(CHANNELS));
    if (fwd_hit)     cur = fwd_data;
    else if (rd_vld) cur = rd_data;
    else             cur = '0;

    t_x       = (TEMP_W+2)'(s1_temp);
    thr_x     = (TEMP_W+2)'(thr[s1_ch]);
    near_lvl  = thr_x - $signed({6'b0, near_margin});
    clear_lvl = thr_x - $signed({6'b0, hysteresis});
    over      = t_x > thr_x;
    cnt_inc   = (cur.cnt != CNT_MAX) ? cur.cnt + 8'd1 : cur.cnt;
    elapsed   = s1_now - cur.last;

    upd = cur;
    ev  = EV_NONE;
    if (!enable_mask[s1_ch]) begin
      upd.status  = STAT_NORMAL;
      upd.latched = 1'b0;
    end else if (s1_rvalid) begin
      if (over)                 upd.status = STAT_ALARM;
      else if (t_x >= near_lvl) upd.status = STAT_NEAR;
      else                      upd.status = STAT_NORMAL;

      if (!cur.latched) begin
        if (over) begin
          upd.cnt = cnt_inc;
          if (cnt_inc >= confirm_count) begin
            upd.latched = 1'b1;
            upd.last    = s1_now;
            ev          = EV_RAISED;
          end
        end else begin
          upd.cnt = '0;
        end
      end else if (t_x <= clear_lvl) begin
        upd.latched = 1'b0;
        upd.cnt     = '0;
        ev          = EV_RECOVER;
      end else if (elapsed >= REMINDER_MS) begin
        upd.last = s1_now;
        ev       = EV_REMIND;
      end
    end

    lat_next = lat_vec;
    if (ch_ok) lat_next[s1_ch] = upd.latched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_ch      <= s1_ch;
      o_status  <= ch_ok ? upd.status  : STAT_NORMAL;
      o_latched <= ch_ok ? upd.latched : 1'b0;
      o_event   <= ch_ok ? ev          : EV_NONE;
      o_any     <= |lat_next;
    end
  end

  assign result.valid         = o_valid;
  assign result.out_channel   = o_ch;
  assign result.status        = o_status;
  assign result.alarm_latched = o_latched;
  assign result.event_res     = o_event;
  assign result.any_latched   = o_any;

endmodule

[design/tal_checker.sv]
// port-level checks of the temperature alarm latch, bound to the top level
module tal_checker import tal_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            valid,
  input logic            ready,
  input logic [CH_W-1:0] out_channel,
  input logic [1:0]      status,
  input logic            alarm_latched,
  input logic [1:0]      event_res,
  input logic            any_latched
);

  // a waiting transaction keeps its channel, event and latch flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_channel) && $stable(event_res)
                        && $stable(alarm_latched))
    else $error("result changed while stalled");

  // a raised alarm only comes with an over-threshold reading
  a_raise: assert property (@(posedge clk) disable iff (rst)
    valid && event_res == EV_RAISED |-> alarm_latched && status == STAT_ALARM)
    else $error("alarm raised without latch or alarm status");

  a_recover: assert property (@(posedge clk) disable iff (rst)
    valid && event_res == EV_RECOVER |-> !alarm_latched && status != STAT_ALARM)
    else $error("recovery reported while still latched");

  a_remind: assert property (@(posedge clk) disable iff (rst)
    valid && event_res == EV_REMIND |-> alarm_latched)
    else $error("reminder on an unlatched channel");

  a_any: assert property (@(posedge clk) disable iff (rst)
    valid && alarm_latched |-> any_latched)
    else $error("latched channel not reflected in any_latched");

endmodule

bind temperature_alarm_latch tal_checker u_tal_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .out_channel   (result.out_channel),
  .status        (result.status),
  .alarm_latched (result.alarm_latched),
  .event_res     (result.event_res),
  .any_latched   (result.any_latched)
);

[tb/temperature_alarm_latch_test.sv]
// testbench of the temperature alarm latch: directed and random readings against a predictor
`timescale 1ns / 100ps

module temperature_alarm_latch_test;
  import tal_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_IDLE    = 13;

  typedef struct {
    logic [CH_W-1:0]          ch;
    logic signed [TEMP_W-1:0] temp;
    logic                     rv;
    logic [TIME_W-1:0]        now;
  } reading_t;

  typedef struct {
    logic [CH_W-1:0] ch;
    status_t         status;
    logic            latched;
    event_t          ev;
    logic            any;
  } alarm_res_t;

  typedef struct {
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  tal_in_if  sample_if ();
  tal_out_if result_if ();
  tal_cfg_if cfg_if ();

  temperature_alarm_latch u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // predictor copy of registers and per-channel state
  logic signed [TEMP_W-1:0] thr_set [CHANNELS];
  logic [CHANNELS-1:0]      enable_set;
  logic [MARGIN_W-1:0]      near_set;
  logic [MARGIN_W-1:0]      hyst_set;
  logic [CNT_W-1:0]         confirm_set;

  status_t           chan_status  [CHANNELS];
  logic              chan_latched [CHANNELS];
  logic [CNT_W-1:0]  chan_count   [CHANNELS];
  logic [TIME_W-1:0] chan_notice  [CHANNELS];

  alarm_res_t pending_alarms [$];
  reg_write_t reg_writes [$];

  int  mismatches;
  bit  feed_idle;
  bit  drain_idle;
  logic [TIME_W-1:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic void reset_model();
    for (int i = 0; i < CHANNELS; i++) begin
      thr_set[i]      = THRESHOLD_RST;
      chan_status[i]  = STAT_NORMAL;
      chan_latched[i] = 1'b0;
      chan_count[i]   = '0;
      chan_notice[i]  = '0;
    end
    enable_set  = ENABLE_RST;
    near_set    = NEAR_RST;
    hyst_set    = HYST_RST;
    confirm_set = CONFIRM_RST;
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_THR0, REG_THR1, REG_THR2, REG_THR3: thr_set[idx[1:0]] = d;
      REG_ENABLE:  enable_set  = d[CHANNELS-1:0];
      REG_NEAR:    near_set    = d[MARGIN_W-1:0];
      REG_HYST:    hyst_set    = d[MARGIN_W-1:0];
      REG_CONFIRM: confirm_set = d[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic any_alarm();
    logic a;
    a = 1'b0;
    for (int i = 0; i < CHANNELS; i++) a |= chan_latched[i];
    return a;
  endfunction

  function automatic alarm_res_t predict_alarm(input reading_t r);
    alarm_res_t o;
    int t, thr_i;
    bit over;
    logic [TIME_W-1:0] elapsed;
    o.ch = r.ch;
    o.ev = EV_NONE;
    if (int'(r.ch) >= CHANNELS) begin
      o.status  = STAT_NORMAL;
      o.latched = 1'b0;
      o.any     = any_alarm();
      return o;
    end
    if (!enable_set[r.ch]) begin
      chan_status[r.ch]  = STAT_NORMAL;
      chan_latched[r.ch] = 1'b0;
    end else if (r.rv) begin
      t     = int'(r.temp);
      thr_i = int'(thr_set[r.ch]);
      over  = t > thr_i;
      if (over) chan_status[r.ch] = STAT_ALARM;
      else if (t >= thr_i - int'(near_set)) chan_status[r.ch] = STAT_NEAR;
      else chan_status[r.ch] = STAT_NORMAL;
      elapsed = r.now - chan_notice[r.ch];
      if (!chan_latched[r.ch]) begin
        if (over) begin
          if (chan_count[r.ch] != CNT_MAX) chan_count[r.ch]++;
          if (chan_count[r.ch] >= confirm_set) begin
            chan_latched[r.ch] = 1'b1;
            chan_notice[r.ch]  = r.now;
            o.ev = EV_RAISED;
          end
        end else begin
          chan_count[r.ch] = '0;
        end
      end else if (t <= thr_i - int'(hyst_set)) begin
        chan_latched[r.ch] = 1'b0;
        chan_count[r.ch]   = '0;
        o.ev = EV_RECOVER;
      end else if (elapsed >= REMINDER_MS) begin
        chan_notice[r.ch] = r.now;
        o.ev = EV_REMIND;
      end
    end
    o.status  = chan_status[r.ch];
    o.latched = chan_latched[r.ch];
    o.any     = any_alarm();
    return o;
  endfunction

  // one reading transaction; valid stays high when the next one follows without a gap
  task automatic send_reading(input logic [CH_W-1:0] ch, input int temp, input bit rv,
                              input logic [TIME_W-1:0] now);
    reading_t r;
    int gap;
    r.ch   = ch;
    r.temp = 16'(temp);
    r.rv   = rv;
    r.now  = now;
    gap = feed_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid         <= 1'b1;
    sample_if.channel       <= r.ch;
    sample_if.temperature   <= r.temp;
    sample_if.reading_valid <= r.rv;
    sample_if.now_ms        <= r.now;
    do @(posedge clk); while (!sample_if.ready);
    pending_alarms.push_back(predict_alarm(r));
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (pending_alarms.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    reg_write_t w;
    w.idx  = idx;
    w.data = d;
    reg_writes.push_back(w);
  endtask

  // writes the queued registers back to back once the block has drained
  task automatic write_regs();
    reg_write_t w;
    wait_idle();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.data;
      do @(posedge clk); while (!cfg_if.ready);
      apply_reg(w.idx, w.data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_defaults();
    send_reading(0, 63, 1, 32'd10);
    send_reading(0, 64, 1, 32'd11);
    send_reading(0, 80, 1, 32'd12);
    send_reading(0, 81, 1, 32'd13);
    send_reading(0, 81, 1, 32'd14);
    send_reading(0, 200, 0, 32'd15);
    send_reading(0, 32767, 1, 32'd100);
    send_reading(1, -32768, 1, 32'd101);
    send_reading(2, 32767, 1, 32'd102);
    send_reading(0, 1000, 0, 32'hFFFF_FFFF);
    send_reading(0, 65, 1, 32'd103);
    send_reading(0, 64, 1, 32'd104);
    send_reading(3, 0, 0, 32'd105);
  endtask

  task automatic test_reminder();
    logic [TIME_W-1:0] w;
    w = 32'hFFF0_0000;
    send_reading(1, 90, 1, 32'd5000);
    send_reading(1, 90, 1, 32'd5001);
    send_reading(1, 90, 1, 32'd5002);
    send_reading(1, 70, 1, 32'd5002 + REMINDER_MS - 1);
    send_reading(1, 70, 1, 32'd5002 + REMINDER_MS);
    send_reading(1, 95, 1, 32'd5002 + 2 * REMINDER_MS - 1);
    // the notice time sits just under the wrap of the millisecond counter
    send_reading(3, 81, 1, w);
    send_reading(3, 81, 1, w);
    send_reading(3, 81, 1, w);
    send_reading(3, 81, 1, w + REMINDER_MS - 1);
    send_reading(3, 81, 1, w + REMINDER_MS);
  endtask

  task automatic test_disable();
    queue_reg(REG_ENABLE, 16'h000D);
    write_regs();
    send_reading(1, 200, 1, 32'd9000);
    send_reading(3, 300, 1, 32'd9001);
    queue_reg(REG_ENABLE, 16'h000F);
    write_regs();
    // counter was kept while disabled, so one reading latches again
    send_reading(1, 81, 1, 32'd9002);
  endtask

  task automatic test_confirm_zero();
    send_reading(2, -100, 1, 32'd12000);
    queue_reg(REG_CONFIRM, 16'h0000);
    write_regs();
    send_reading(2, 81, 1, 32'd12001);
    send_reading(2, 0, 1, 32'd12002);
    queue_reg(REG_CONFIRM, 16'h0001);
    write_regs();
    send_reading(2, 81, 1, 32'd12003);
  endtask

  task automatic test_saturation();
    feed_idle = 1'b0;
    send_reading(0, 0, 1, 32'd20000);
    queue_reg(REG_CONFIRM, 16'h00FF);
    write_regs();
    for (int i = 0; i < 255; i++) send_reading(0, 200, 1, 32'd20001 + i);
    queue_reg(REG_ENABLE, 16'h000E);
    write_regs();
    send_reading(0, 200, 1, 32'd21000);
    queue_reg(REG_ENABLE, 16'h000F);
    write_regs();
    // counter pinned at its maximum: one more over reading latches
    send_reading(0, 200, 1, 32'd21001);
    send_reading(0, 0, 1, 32'd21002);
    send_reading(0, 200, 1, 32'd21003);
    feed_idle = 1'b1;
  endtask

  task automatic test_extremes();
    queue_reg(REG_THR0, 16'h8000);
    queue_reg(REG_THR1, 16'h7FFF);
    queue_reg(REG_THR2, 16'h0000);
    queue_reg(REG_NEAR, 16'h0FFF);
    queue_reg(REG_HYST, 16'h0FFF);
    queue_reg(REG_CONFIRM, 16'h0001);
    write_regs();
    send_reading(0, -32768, 1, 32'd30000);
    send_reading(0, -32767, 1, 32'd30001);
    send_reading(0, -32768, 1, 32'd30002);
    send_reading(1, 32767, 1, 32'd30003);
    send_reading(1, 28672, 1, 32'd30004);
    send_reading(1, 28671, 1, 32'd30005);
    queue_reg(REG_NEAR, 16'h0000);
    queue_reg(REG_HYST, 16'h0000);
    write_regs();
    send_reading(2, 0, 1, 32'd30006);
    send_reading(2, -1, 1, 32'd30007);
    send_reading(2, 1, 1, 32'd30008);
    send_reading(2, 0, 1, 32'd30009);
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] keep);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    return (v & keep) | (junk & ~keep);
  endfunction

  task automatic random_setting(input int kind);
    logic [CFG_DATA_W-1:0] thr_v, en_v, near_v, hyst_v, conf_v;
    for (int i = 0; i < THR_REGS; i++) begin
      case (kind)
        1: case ($urandom_range(0, 3))
             0: thr_v = 16'h8000;
             1: thr_v = 16'h7FFF;
             2: thr_v = 16'h8001;
             default: thr_v = 16'h7FFE;
           endcase
        3: thr_v = CFG_DATA_W'($urandom);
        default: thr_v = CFG_DATA_W'(int'($urandom_range(0, 400)) - 200);
      endcase
      queue_reg(cfg_reg_t'(REG_THR0 + i), thr_v);
    end
    en_v   = (kind == 2 || $urandom_range(0, 2) == 0) ?
             CFG_DATA_W'($urandom_range(0, 15)) : 16'd15;
    near_v = CFG_DATA_W'($urandom_range(0, 64));
    hyst_v = CFG_DATA_W'($urandom_range(0, 64));
    conf_v = CFG_DATA_W'($urandom_range(1, 6));
    if (kind == 1) begin
      near_v = $urandom_range(0, 1) ? 16'h0FFF : 16'h0000;
      hyst_v = $urandom_range(0, 1) ? 16'h0FFF : 16'h0000;
      conf_v = $urandom_range(0, 1) ? 16'h00FF : 16'h0001;
    end else if (kind == 3) begin
      near_v = CFG_DATA_W'($urandom_range(0, 4095));
      hyst_v = CFG_DATA_W'($urandom_range(0, 4095));
      conf_v = '0;
    end
    // unused upper data bits carry noise
    queue_reg(REG_ENABLE, with_junk(en_v, 16'h000F));
    queue_reg(REG_NEAR, with_junk(near_v, 16'h0FFF));
    queue_reg(REG_HYST, with_junk(hyst_v, 16'h0FFF));
    queue_reg(REG_CONFIRM, with_junk(conf_v, 16'h00FF));
    write_regs();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    bit heating [CHANNELS];
    logic [CH_W-1:0] ch;
    int v, thr_i, span;
    int roll;
    for (int i = 0; i < CHANNELS; i++) heating[i] = 1'b0;
    ch = '0;
    clock_ms = $urandom;
    for (int p = 0; p < phases; p++) begin
      random_setting(p % 4);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 39) == 0) feed_idle = ~feed_idle;
        if ($urandom_range(0, 39) == 0) drain_idle = ~drain_idle;
        if ($urandom_range(0, 9) >= 6) ch = CH_W'($urandom_range(0, CHANNELS - 1));
        thr_i = int'(thr_set[ch]);
        span  = ((near_set > hyst_set) ? int'(near_set) : int'(hyst_set)) + 8;
        if ($urandom_range(0, 99) < 15) begin
          v = int'($signed(16'($urandom)));
        end else begin
          if ($urandom_range(0, 7) == 0) heating[ch] = ~heating[ch];
          if (heating[ch]) v = thr_i + int'($urandom_range(1, 8));
          else v = thr_i - int'($urandom_range(0, span));
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) clock_ms += $urandom_range(0, 300000);
        else if (roll < 92) clock_ms += $urandom_range(1799990, 1800010);
        else clock_ms = $urandom;
        send_reading(ch, v, $urandom_range(0, 9) != 0, clock_ms);
      end
    end
    feed_idle  = 1'b1;
    drain_idle = 1'b1;
  endtask

  // result side: random stalls before each transaction
  initial begin : result_drain
    int stall;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = drain_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  always @(posedge clk) begin : result_check
    alarm_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_alarms.size() == 0) begin
        flag_error($sformatf("unexpected result on channel %0d", result_if.out_channel));
      end else begin
        want = pending_alarms.pop_front();
        if (result_if.out_channel !== want.ch || result_if.status !== want.status ||
            result_if.alarm_latched !== want.latched || result_if.event_res !== want.ev ||
            result_if.any_latched !== want.any)
          flag_error($sformatf({"result mismatch: expected ch %0d status %0d latched %0d ",
                                "event %0d any %0d, got ch %0d status %0d latched %0d ",
                                "event %0d any %0d"},
                               want.ch, want.status, want.latched, want.ev, want.any,
                               result_if.out_channel, result_if.status,
                               result_if.alarm_latched, result_if.event_res,
                               result_if.any_latched));
      end
    end
  end

  // ends the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("temperature_alarm_latch_test: done, errors");
    $finish;
  end

  initial begin : main
    mismatches = 0;
    feed_idle  = 1'b1;
    drain_idle = 1'b1;
    reset_model();
    rst                     <= 1'b1;
    sample_if.valid         <= 1'b0;
    sample_if.channel       <= '0;
    sample_if.temperature   <= '0;
    sample_if.reading_valid <= 1'b0;
    sample_if.now_ms        <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= REG_THR0;
    cfg_if.data             <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_reminder();
    test_disable();
    test_confirm_zero();
    test_saturation();
    test_extremes();
    test_random(8, 50);

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_alarms.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_alarms.size()));
    if (mismatches == 0)
      $display("temperature_alarm_latch_test: done, clean");
    else
      $display("temperature_alarm_latch_test: done, errors");
    $finish;
  end

endmodule

[files.f]
design/tal_pkg.sv
design/tal_if.sv
design/temperature_alarm_latch.sv
design/tal_checker.sv
tb/temperature_alarm_latch_test.sv
